// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the sensor frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Frame layout
  localparam logic [7:0] HeaderByte = 8'h55;
  localparam int         FrameLen   = 11;
  localparam int         CountW     = $clog2(FrameLen);
  localparam logic [CountW-1:0] CsumPos   = CountW'(FrameLen - 1);
  localparam logic [CountW-1:0] ChanPos   = CountW'(3);
  localparam logic [CountW-1:0] TdsHiPos  = CountW'(4);
  localparam logic [CountW-1:0] TdsLoPos  = CountW'(5);
  localparam logic [CountW-1:0] TempHiPos = CountW'(6);
  localparam logic [CountW-1:0] TempLoPos = CountW'(7);

  // Field widths
  localparam int TimeoutW = 16;
  localparam int GainW    = 10;
  localparam int RawW     = 16;
  localparam int TdsW     = 26;

  // Register reset values
  localparam logic [TimeoutW-1:0] TimeoutRst = 16'd1000;
  localparam logic [GainW-1:0]    GainRst    = 10'd47;

  // Register indexes
  localparam logic CfgIdleTimeout = 1'b0;
  localparam logic CfgTdsGain     = 1'b1;

  // Result status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusCsumErr = 1'b1;

  // Input item kind
  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } sfr_func_e;

  typedef struct packed {
    logic [TimeoutW-1:0] idle_timeout_ms;
    logic [GainW-1:0]    tds_gain;
  } sfr_cfg_t;

  typedef struct packed {
    logic              status;
    logic [7:0]        channel_id;
    logic [TdsW-1:0]   tds_scaled;
    logic [RawW-1:0]   temperature_tenths;
  } sfr_result_t;

endpackage

// ===== sv/sfr_if.sv =====
// ----------------------------------------------------------------------------
// sfr_rx_if / sfr_res_if
// Valid/ready channels for received items and for frame results.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface sfr_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  channel_id;
  logic [25:0] tds_scaled;
  logic [15:0] temperature_tenths;

  modport source (output valid, output status, output channel_id, output tds_scaled,
                  output temperature_tenths, input ready);
  modport sink   (input valid, input status, input channel_id, input tds_scaled,
                  input temperature_tenths, output ready);
endinterface

// ===== sv/sfr_core.sv =====
// ----------------------------------------------------------------------------
// sfr_core
// Frame parser state: byte position, running sum, captured fields, idle
// timer. Produces at most one result per accepted transaction.
// ----------------------------------------------------------------------------
module sfr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                func_i,
  input  logic [7:0]          rx_byte_i,
  input  sfr_pkg::sfr_cfg_t   cfg_i,
  output logic                res_valid_o,
  output sfr_pkg::sfr_result_t res_o
);
  import sfr_pkg::*;

  logic [CountW-1:0]   count_q, count_d;
  logic [7:0]          sum_q, sum_d;
  logic [TimeoutW-1:0] idle_q, idle_d;
  logic [7:0]          chan_q, chan_d;
  logic [RawW-1:0]     tds_q, tds_d;
  logic [RawW-1:0]     temp_q, temp_d;

  logic [TimeoutW-1:0] idle_inc;
  logic [TdsW-1:0]     tds_prod;
  logic [7:0]          sum_next;

  // Saturating tick count and scaled reading
  assign idle_inc = (idle_q != {TimeoutW{1'b1}}) ? idle_q + TimeoutW'(1) : idle_q;
  assign tds_prod = tds_q * cfg_i.tds_gain;
  assign sum_next = sum_q + rx_byte_i;

  // Next state and result
  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    idle_d      = idle_q;
    chan_d      = chan_q;
    tds_d       = tds_q;
    temp_d      = temp_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      if (func_i == FUNC_TICK) begin
        // Count idle time, drop a stale partial frame
        if (count_q != '0) begin
          idle_d = idle_inc;
          if (idle_inc > cfg_i.idle_timeout_ms) begin
            count_d = '0;
            sum_d   = '0;
            idle_d  = '0;
          end
        end
      end else begin
        idle_d = '0;
        if (count_q != '0 || rx_byte_i == HeaderByte) begin
          // Capture payload bytes
          case (count_q)
            ChanPos:   chan_d = rx_byte_i;
            TdsHiPos:  tds_d  = {rx_byte_i, tds_q[7:0]};
            TdsLoPos:  tds_d  = {tds_q[15:8], rx_byte_i};
            TempHiPos: temp_d = {rx_byte_i, temp_q[7:0]};
            TempLoPos: temp_d = {temp_q[15:8], rx_byte_i};
            default: ;
          endcase
          if (count_q < CsumPos) begin
            sum_d   = sum_next;
            count_d = count_q + CountW'(1);
          end else begin
            // Checksum byte: emit result and restart
            res_valid_o = 1'b1;
            if (sum_q == rx_byte_i) begin
              res_o.status             = StatusOk;
              res_o.channel_id         = chan_q;
              res_o.tds_scaled         = tds_prod;
              res_o.temperature_tenths = temp_q;
            end else begin
              res_o.status = StatusCsumErr;
            end
            count_d = '0;
            sum_d   = '0;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      idle_q  <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      idle_q  <= idle_d;
    end
  end

  // Captured frame fields
  always_ff @(posedge clk_i) begin
    chan_q <= chan_d;
    tds_q  <= tds_d;
    temp_q <= temp_d;
  end

endmodule

// ===== sv/sfr_skid.sv =====
// ----------------------------------------------------------------------------
// sfr_skid
// Output register with one skid entry so the parser keeps running while
// a result waits downstream.
// ----------------------------------------------------------------------------
module sfr_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sfr_pkg::sfr_result_t data_i,
  output logic                 space_o,
  sfr_res_if.source            res_o
);
  import sfr_pkg::*;

  logic        main_v_q, main_v_d;
  logic        spare_v_q, spare_v_d;
  sfr_result_t main_q, main_d;
  sfr_result_t spare_q, spare_d;
  logic        pop;

  assign pop     = main_v_q & res_o.ready;
  assign space_o = ~spare_v_q;

  // Advance entries
  always_comb begin
    main_v_d  = main_v_q;
    spare_v_d = spare_v_q;
    main_d    = main_q;
    spare_d   = spare_q;
    if (spare_v_q) begin
      if (pop) begin
        main_d    = spare_q;
        spare_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q || pop) begin
        main_d   = data_i;
        main_v_d = 1'b1;
      end else begin
        spare_d   = data_i;
        spare_v_d = 1'b1;
      end
    end else if (pop) begin
      main_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q  <= 1'b0;
      spare_v_q <= 1'b0;
    end else begin
      main_v_q  <= main_v_d;
      spare_v_q <= spare_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q  <= main_d;
    spare_q <= spare_d;
  end

  // Drive the result channel
  assign res_o.valid              = main_v_q;
  assign res_o.status             = main_q.status;
  assign res_o.channel_id         = main_q.channel_id;
  assign res_o.tds_scaled         = main_q.tds_scaled;
  assign res_o.temperature_tenths = main_q.temperature_tenths;

endmodule

// ===== sv/sensor_frame_receiver_sum8.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_receiver_sum8
// Serial sensor frame receiver with 8-bit additive checksum.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: a received byte or a millisecond tick.
// Each transaction updates the parser state in the cycle it is accepted; the
// checksum byte of an 11-byte frame (header 0x55) produces one result, which
// is registered in the output register, or the skid entry while that is full.
// These two absorb downstream stalls, so rx ready drops only when both hold
// results. A good frame reports channel byte, TDS count times tds_gain and
// temperature in tenths; a bad sum reports status 1 with zeroed fields.
// A partial frame is discarded once the tick count exceeds idle_timeout_ms.
// Registers (cfg_idx_i): 0 idle_timeout_ms (reset 1000), 1 tds_gain (reset 47).
// ----------------------------------------------------------------------------
module sensor_frame_receiver_sum8 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  sfr_rx_if.sink      rx_i,
  sfr_res_if.source   res_o
);
  import sfr_pkg::*;

  sfr_cfg_t    cfg_q;
  sfr_result_t core_res;
  logic        core_res_valid;
  logic        space;
  logic        accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_timeout_ms <= TimeoutRst;
      cfg_q.tds_gain        <= GainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdleTimeout: cfg_q.idle_timeout_ms <= cfg_data_i;
        CfgTdsGain:     cfg_q.tds_gain        <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Accept while the skid entry is free
  assign rx_i.ready = space;
  assign accept     = rx_i.valid & space;

  sfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (rx_i.func),
    .rx_byte_i   (rx_i.rx_byte),
    .cfg_i       (cfg_q),
    .res_valid_o (core_res_valid),
    .res_o       (core_res)
  );

  sfr_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_res_valid),
    .data_i  (core_res),
    .space_o (space),
    .res_o   (res_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor frame receiver with 8-bit sum.
// ----------------------------------------------------------------------------
// The stimulus block queues serial bytes and millisecond ticks for a clocked
// driver. The driver replays every accepted transaction through a behavioral
// parser in the bench, which queues the reading that each complete frame
// should produce. A clocked monitor checks each delivered reading against
// the oldest one waiting. The run covers several register settings, among
// them the timeout and gain extremes, timeout boundaries, and a long
// downstream stall that backs up the receiver.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int SettleCycles  = 8;
  localparam int CycleLimit    = 1_000_000;
  localparam int HoldCycles    = 300;
  localparam int PhaseItems    = 80;
  localparam int NumPhases     = 6;
  localparam int PressurePhase = 4;

  typedef struct packed {
    sfr_func_e  kind;
    logic [7:0] data;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_data;

  sfr_rx_if  rx_if ();
  sfr_res_if res_if ();

  sensor_frame_receiver_sum8 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stimulus backlog and readings still owed by the block
  rx_item_t    rx_backlog[$];
  sfr_result_t pending_readings[$];

  // Parser state kept by the bench
  logic [TimeoutW-1:0] timeout_limit = TimeoutRst;
  logic [GainW-1:0]    gain_copy     = GainRst;
  logic [CountW-1:0]   frame_pos     = '0;
  logic [7:0]          running_sum   = '0;
  logic [7:0]          chan_latch    = '0;
  logic [RawW-1:0]     tds_latch     = '0;
  logic [RawW-1:0]     temp_latch    = '0;
  logic [15:0]         idle_count    = '0;

  int errors          = 0;
  int items_queued    = 0;
  int items_accepted  = 0;
  int readings_seen   = 0;
  int frames_good     = 0;
  int frames_bad      = 0;
  int frames_timedout = 0;
  int reg_writes      = 0;
  int cycle_count     = 0;

  bit calm_src  = 1'b0;
  bit calm_sink = 1'b0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int src_gap       = 0;
  int sink_gap      = 0;

  rx_item_t    next_item;
  sfr_result_t got_reading;

  // Most gaps are short, a few are long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Advance the parser by one accepted transaction
  task automatic parse_rx_item(input sfr_func_e kind, input logic [7:0] b);
    sfr_result_t r;
    if (kind == FUNC_TICK) begin
      if (frame_pos != 0) begin
        if (idle_count != 16'hFFFF) idle_count++;
        if (idle_count > timeout_limit) begin
          frame_pos = '0;
          running_sum = '0;
          idle_count = '0;
          frames_timedout++;
        end
      end
    end else begin
      idle_count = '0;
      if (frame_pos != 0 || b == HeaderByte) begin
        case (frame_pos)
          ChanPos:   chan_latch = b;
          TdsHiPos:  tds_latch[15:8] = b;
          TdsLoPos:  tds_latch[7:0] = b;
          TempHiPos: temp_latch[15:8] = b;
          TempLoPos: temp_latch[7:0] = b;
          default: ;
        endcase
        if (frame_pos != CsumPos) begin
          running_sum = running_sum + b;
          frame_pos = frame_pos + 1'b1;
        end else begin
          if (running_sum == b) begin
            r.status = StatusOk;
            r.channel_id = chan_latch;
            r.tds_scaled = TdsW'(32'(tds_latch) * 32'(gain_copy));
            r.temperature_tenths = temp_latch;
            frames_good++;
          end else begin
            r = '0;
            r.status = StatusCsumErr;
            frames_bad++;
          end
          pending_readings.insert(pending_readings.size(), r);
          frame_pos = '0;
          running_sum = '0;
          idle_count = '0;
        end
      end
    end
  endtask

  task automatic push_item(input sfr_func_e kind, input logic [7:0] data);
    rx_item_t it;
    it.kind = kind;
    it.data = data;
    rx_backlog.insert(rx_backlog.size(), it);
    items_queued++;
  endtask

  // Ticks carry a random byte, which the block must ignore
  task automatic push_ticks(input int n);
    repeat (n) push_item(FUNC_TICK, 8'($urandom));
  endtask

  // Queue a frame, possibly cut short, corrupted or spread out by ticks
  task automatic queue_frame(input bit corrupt, input int keep_len, input bit tick_gaps,
                             input int header_ticks, input logic [7:0] chan,
                             input logic [15:0] tds, input logic [15:0] temp);
    logic [7:0] fb [FrameLen];
    logic [7:0] sum;
    int span;
    fb[0] = HeaderByte;
    fb[1] = 8'($urandom);
    fb[2] = 8'($urandom);
    fb[ChanPos] = chan;
    fb[TdsHiPos] = tds[15:8];
    fb[TdsLoPos] = tds[7:0];
    fb[TempHiPos] = temp[15:8];
    fb[TempLoPos] = temp[7:0];
    fb[8] = 8'($urandom);
    fb[9] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < FrameLen - 1; i++) sum = sum + fb[i];
    fb[FrameLen-1] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
    // Straddle the timeout when it is small
    span = (timeout_limit < 6) ? int'(timeout_limit) + 1 : 4;
    for (int i = 0; i < keep_len; i++) begin
      if (i == 1) push_ticks(header_ticks);
      if (tick_gaps && i > 0 && $urandom_range(0, 4) == 0) push_ticks($urandom_range(0, span));
      push_item(FUNC_BYTE, fb[i]);
    end
  endtask

  task automatic queue_random_frame(input bit corrupt, input int keep_len);
    logic [7:0] chan;
    chan = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom);
    queue_frame(corrupt, keep_len, 1'b1, 0, chan, 16'($urandom), 16'($urandom));
  endtask

  // Hold until the backlog is sent and every reading has come back
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (rx_backlog.size() != 0 || rx_if.valid || pending_readings.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    if (idx == CfgIdleTimeout) timeout_limit = data;
    else gain_copy = data[GainW-1:0];
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Finish any partial frame so the next one starts at the header
  task automatic realign();
    if (frame_pos != 0) repeat (FrameLen - frame_pos) push_item(FUNC_BYTE, 8'($urandom));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("[%0t] %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // Drive known values before the first edge
  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CfgIdleTimeout;
    cfg_data = '0;
    rx_if.valid = 1'b0;
    rx_if.func = FUNC_BYTE;
    rx_if.rx_byte = '0;
    res_if.ready = 1'b0;
  end

  // Sender: offer the backlog, record each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        parse_rx_item(sfr_func_e'(rx_if.func), rx_if.rx_byte);
        items_accepted++;
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          rx_if.valid <= 1'b0;
        end else if (rx_backlog.size() != 0) begin
          next_item = rx_backlog.pop_front();
          rx_if.valid <= 1'b1;
          rx_if.func <= next_item.kind;
          rx_if.rx_byte <= next_item.data;
          src_gap = calm_src ? 0 : draw_gap();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each reading, then stall at random or on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        readings_seen++;
        if (pending_readings.size() == 0) begin
          errors++;
          $display("[%0t] reading: expected none, actual status %0d ch 0x%0h tds %0d temp %0d",
                   $time, res_if.status, res_if.channel_id, res_if.tds_scaled,
                   res_if.temperature_tenths);
        end else begin
          got_reading = pending_readings.pop_front();
          check_field("status", 32'(got_reading.status), 32'(res_if.status));
          check_field("channel_id", 32'(got_reading.channel_id), 32'(res_if.channel_id));
          check_field("tds_scaled", 32'(got_reading.tds_scaled), 32'(res_if.tds_scaled));
          check_field("temperature_tenths", 32'(got_reading.temperature_tenths),
                      32'(res_if.temperature_tenths));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = HoldCycles;
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        sink_gap = calm_sink ? 0 : draw_gap();
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[%0t] run stopped at the cycle limit with %0d readings owed", $time,
               pending_readings.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int timeouts [NumPhases];
    int gains [NumPhases];
    int start;
    int r;
    timeouts = '{2, 0, 65535, 5, 1000, 40000};
    gains    = '{1023, 0, 1, 512, 47, 0};
    gains[NumPhases-1] = $urandom_range(0, 1023);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle tick with header byte, non-header bytes, extreme frame,
    // bad checksum, ticks inside a frame below the reset timeout
    push_item(FUNC_TICK, HeaderByte);
    push_item(FUNC_BYTE, 8'h54);
    push_item(FUNC_BYTE, 8'hAA);
    queue_frame(1'b0, FrameLen, 1'b0, 0, 8'd1, 16'hFFFF, 16'hFFFF);
    queue_frame(1'b1, FrameLen, 1'b0, 3, 8'hFE, 16'h0000, 16'h0000);

    for (int p = 0; p < NumPhases; p++) begin
      wait_quiet();
      write_reg(CfgIdleTimeout, 16'(timeouts[p]));
      write_reg(CfgTdsGain, {6'($urandom), 10'(gains[p])});
      realign();
      calm_src  = ($urandom_range(0, 3) == 0);
      calm_sink = ($urandom_range(0, 3) == 0);

      // Timeout boundary: exactly the limit survives, one more tick drops
      if (timeout_limit < 8) begin
        queue_frame(1'b0, FrameLen, 1'b0, int'(timeout_limit), 8'($urandom),
                    16'($urandom), 16'($urandom));
        queue_frame(1'b0, FrameLen, 1'b0, int'(timeout_limit) + 1, 8'($urandom),
                    16'($urandom), 16'($urandom));
      end

      // Back up the block behind a long receiver stall
      if (p == PressurePhase) begin
        calm_src = 1'b1;
        hold_requests++;
        repeat (6) queue_frame(1'b0, FrameLen, 1'b0, 0, 8'($urandom), 16'($urandom),
                               16'($urandom));
        wait_quiet();
        calm_src = 1'b0;
      end

      // Mostly well-formed frames, some cut short, some line noise
      start = items_queued;
      while (items_queued - start < PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          queue_random_frame(r < 14, FrameLen);
        end else if (r < 85) begin
          queue_random_frame(1'b0, $urandom_range(1, FrameLen - 1));
        end else begin
          repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 1) == 0) push_ticks(1);
            else if ($urandom_range(0, 3) == 0) push_item(FUNC_BYTE, HeaderByte);
            else push_item(FUNC_BYTE, 8'($urandom));
          end
        end
      end
    end

    wait_quiet();
    if (pending_readings.size() != 0) begin
      errors++;
      $display("[%0t] %0d readings never delivered", $time, pending_readings.size());
    end
    $display("Run: %0d transactions in, %0d readings out over %0d register writes",
             items_accepted, readings_seen, reg_writes);
    $display("Frames: %0d good, %0d bad checksum, %0d dropped on idle timeout",
             frames_good, frames_bad, frames_timedout);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
